// ===== rtl/bvst_pkg.sv =====
// Shared types and constants for the binary vertex search block.
package bvst_pkg;

  localparam int MAX_ROWS   = 16;
  localparam int MAX_LEN    = 1024;
  localparam int SMP_W      = 16;
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COL_W      = $clog2(MAX_LEN);
  localparam int CNT_W      = $clog2(MAX_ROWS + 1);
  localparam int LEN_W      = 11;
  localparam int SLOTS      = MAX_ROWS + 1;
  localparam int VAL_W      = 21;
  localparam int MAG_W      = 21;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int DIST_W     = 56;
  localparam int IN_W       = 40;
  localparam int OUT_W      = 96;

  localparam logic signed [VAL_W-1:0] VAL_HI = 21'sd524287;
  localparam logic signed [VAL_W-1:0] VAL_LO = -21'sd524288;

  typedef enum logic [1:0] {
    ACT_LOAD_ROW  = 2'd0,
    ACT_LOAD_MEAN = 2'd1,
    ACT_RUN       = 2'd2,
    ACT_READ      = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_ROWS = 2'd0,
    REG_LEN  = 2'd1,
    REG_LOW  = 2'd2,
    REG_HIGH = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_START,
    ST_RD_GO,
    ST_RD_WAIT,
    ST_S_PAT,
    ST_S_ESTART,
    ST_S_EWAIT,
    ST_S_SQWAIT,
    ST_S_PEND,
    ST_S_FIND,
    ST_S_MAX,
    ST_S_NEXT
  } state_t;

  typedef struct packed {
    logic                start;
    logic [MAX_ROWS-1:0] pattern;
    logic [CNT_W-1:0]    nrows;
    logic [COL_W-1:0]    col;
  } elem_req_t;

  typedef struct packed {
    logic                    row_we;
    logic                    mean_we;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [SMP_W-1:0] data;
  } mem_wr_t;

endpackage

// ===== rtl/binary_vertex_search_topk.sv =====
// Binary vertex search top level: stores, sequencer and the kept slots.
// Load and mean words go straight into the stores. A read word rebuilds the element with one
// adder over the mean and the row entries its pattern selects among all 16 rows, one store
// read per cycle. A run word scores M elements per pattern over 2^K patterns, and each slot
// replacement adds a slot search and a worst-sum sweep; once the slots are filled, a
// pattern stops early when its sum passes the current worst. The block takes no word while
// a read or a run is in progress.
module binary_vertex_search_topk (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // action[1:0], row_index[5:2], column_index[15:6], sample[31:16],
  // slot_index[36:32], zero fill
  input  logic [bvst_pkg::IN_W-1:0]      in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // entry_pattern[15:0], entry_distance[71:16], entry_value[92:72], zero fill
  output logic [bvst_pkg::OUT_W-1:0]     out_tdata,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [15:0]                    cfg_wdata
);
  import bvst_pkg::*;

  state_t state_r, state_nxt;

  logic [4:0]              rows_r;
  logic [LEN_W-1:0]        len_r;
  logic signed [SMP_W-1:0] low_r;
  logic signed [SMP_W-1:0] high_r;

  logic [MAX_ROWS-1:0]     slot_pat_r  [SLOTS];
  logic [DIST_W-1:0]       slot_dist_r [SLOTS];
  logic [DIST_W-1:0]       worst_r;
  logic [DIST_W-1:0]       macc_r;
  logic [4:0]              idx_r;

  logic [CNT_W-1:0]        k_r;
  logic [LEN_W-1:0]        m_r;
  logic [MAX_ROWS-1:0]     p_r;
  logic [COL_W-1:0]        j_r;
  logic [DIST_W-1:0]       sum_r;
  logic [COL_W-1:0]        col_r;
  logic [MAX_ROWS-1:0]     rpat_r;
  logic [DIST_W-1:0]       rdist_r;

  logic                    out_valid_r;
  logic [MAX_ROWS-1:0]     o_pat_r;
  logic [DIST_W-1:0]       o_dist_r;
  logic signed [VAL_W-1:0] o_val_r;

  action_t                 in_action;
  logic [ROW_W-1:0]        in_row;
  logic [COL_W-1:0]        in_col;
  logic signed [SMP_W-1:0] in_sample;
  logic [4:0]              in_slot;
  logic                    in_fire;

  elem_req_t               req;
  mem_wr_t                 wr;
  logic                    e_done;
  logic signed [VAL_W-1:0] e_value;
  logic                    sq_valid;
  logic [SQ_W-1:0]         sq;

  logic [CNT_W-1:0]        k_calc;
  logic [LEN_W-1:0]        m_calc;
  logic [DIST_W:0]         sum_wide;
  logic [DIST_W-1:0]       sum_add;
  logic                    fill;
  logic                    last_col;
  logic [MAX_ROWS-1:0]     last_pat;
  logic [DIST_W-1:0]       macc_nxt;

  assign in_action = action_t'(in_tdata[1:0]);
  assign in_row    = in_tdata[5:2];
  assign in_col    = in_tdata[15:6];
  assign in_sample = in_tdata[31:16];
  assign in_slot   = in_tdata[36:32];

  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;

  assign k_calc = (rows_r == 5'd0) ? CNT_W'(1) :
                  (rows_r > 5'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : CNT_W'(rows_r);
  assign m_calc = (len_r == '0) ? LEN_W'(1) :
                  (len_r > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : len_r;

  assign sum_wide = {1'b0, sum_r} + (DIST_W+1)'(sq);
  assign sum_add  = sum_wide[DIST_W] ? {DIST_W{1'b1}} : sum_wide[DIST_W-1:0];
  assign fill     = ({11'd0, k_r} >= p_r);
  assign last_col = (j_r == COL_W'(m_r - LEN_W'(1)));
  assign last_pat = MAX_ROWS'(((MAX_ROWS+1)'(1) << k_r) - (MAX_ROWS+1)'(1));
  assign macc_nxt = (slot_dist_r[idx_r] > macc_r) ? slot_dist_r[idx_r] : macc_r;

  always_comb begin
    wr.row_we  = in_fire && (in_action == ACT_LOAD_ROW);
    wr.mean_we = in_fire && (in_action == ACT_LOAD_MEAN);
    wr.row     = in_row;
    wr.col     = in_col;
    wr.data    = in_sample;
    req.start  = (state_r == ST_RD_GO) || (state_r == ST_S_ESTART);
    req.pattern = (state_r == ST_RD_GO) ? rpat_r : p_r;
    req.nrows  = (state_r == ST_RD_GO) ? CNT_W'(MAX_ROWS) : k_r;
    req.col    = (state_r == ST_RD_GO) ? col_r : j_r;
  end

  bvst_elem u_elem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .wr    (wr),
    .done  (e_done),
    .value (e_value)
  );

  bvst_gap u_gap (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (e_done && (state_r == ST_S_EWAIT)),
    .a        (e_value),
    .lo       (low_r),
    .hi       (high_r),
    .sq_valid (sq_valid),
    .sq       (sq)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_action == ACT_RUN)) begin
          state_nxt = ST_S_PAT;
        end else if (in_fire && (in_action == ACT_READ)) begin
          state_nxt = ST_RD_START;
        end
      end
      ST_RD_START: state_nxt = (idx_r > 5'(MAX_ROWS)) ? ST_IDLE : ST_RD_GO;
      ST_RD_GO:    state_nxt = ST_RD_WAIT;
      ST_RD_WAIT:  if (e_done) begin
        state_nxt = ST_IDLE;
      end
      ST_S_PAT:    state_nxt = ST_S_ESTART;
      ST_S_ESTART: state_nxt = ST_S_EWAIT;
      ST_S_EWAIT:  if (e_done) begin
        state_nxt = ST_S_SQWAIT;
      end
      ST_S_SQWAIT: begin
        if (sq_valid) begin
          if (last_col) begin
            state_nxt = ST_S_PEND;
          end else if (!fill && (sum_add > worst_r)) begin
            state_nxt = ST_S_NEXT;
          end else begin
            state_nxt = ST_S_ESTART;
          end
        end
      end
      ST_S_PEND: begin
        if (fill || (sum_r > worst_r)) begin
          state_nxt = ST_S_NEXT;
        end else begin
          state_nxt = ST_S_FIND;
        end
      end
      ST_S_FIND: if (slot_dist_r[idx_r] == worst_r) begin
        state_nxt = ST_S_MAX;
      end
      ST_S_MAX: if (idx_r == 5'(k_r)) begin
        state_nxt = ST_S_NEXT;
      end
      ST_S_NEXT: state_nxt = (p_r == last_pat) ? ST_IDLE : ST_S_PAT;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= 5'd8;
      len_r  <= LEN_W'(1024);
      low_r  <= '0;
      high_r <= 16'sd4096;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ROWS: rows_r <= cfg_wdata[4:0];
        REG_LEN:  len_r  <= cfg_wdata[LEN_W-1:0];
        REG_LOW:  low_r  <= cfg_wdata;
        REG_HIGH: high_r <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SLOTS; s++) begin
        slot_pat_r[s]  <= '0;
        slot_dist_r[s] <= '0;
      end
      worst_r     <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire && (in_action == ACT_RUN)) begin
            k_r     <= k_calc;
            m_r     <= m_calc;
            p_r     <= '0;
            worst_r <= '0;
          end
          if (in_fire && (in_action == ACT_READ)) begin
            idx_r <= in_slot;
            col_r <= in_col;
          end
        end
        ST_RD_START: begin
          if (idx_r > 5'(MAX_ROWS)) begin
            o_pat_r     <= '0;
            o_dist_r    <= '0;
            o_val_r     <= '0;
            out_valid_r <= 1'b1;
          end else begin
            rpat_r  <= slot_pat_r[idx_r];
            rdist_r <= slot_dist_r[idx_r];
          end
        end
        ST_RD_WAIT: begin
          if (e_done) begin
            o_pat_r     <= rpat_r;
            o_dist_r    <= rdist_r;
            o_val_r     <= (e_value > VAL_HI) ? VAL_HI :
                           (e_value < VAL_LO) ? VAL_LO : e_value;
            out_valid_r <= 1'b1;
          end
        end
        ST_S_PAT: begin
          j_r   <= '0;
          sum_r <= '0;
        end
        ST_S_SQWAIT: begin
          if (sq_valid) begin
            sum_r <= sum_add;
            j_r   <= j_r + COL_W'(1);
          end
        end
        ST_S_PEND: begin
          if (fill) begin
            slot_pat_r[p_r[4:0]]  <= p_r;
            slot_dist_r[p_r[4:0]] <= sum_r;
            if (sum_r > worst_r) begin
              worst_r <= sum_r;
            end
          end
          idx_r <= '0;
        end
        ST_S_FIND: begin
          if (slot_dist_r[idx_r] == worst_r) begin
            slot_pat_r[idx_r]  <= p_r;
            slot_dist_r[idx_r] <= sum_r;
            idx_r  <= '0;
            macc_r <= '0;
          end else begin
            idx_r <= idx_r + 5'd1;
          end
        end
        ST_S_MAX: begin
          macc_r <= macc_nxt;
          if (idx_r == 5'(k_r)) begin
            worst_r <= macc_nxt;
          end else begin
            idx_r <= idx_r + 5'd1;
          end
        end
        ST_S_NEXT: begin
          p_r <= p_r + MAX_ROWS'(1);
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, o_val_r, o_dist_r, o_pat_r};

endmodule

// ===== rtl/bvst_elem.sv =====
// Row and mean stores with a shared accumulator that sums one candidate element.
module bvst_elem (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bvst_pkg::elem_req_t              req,
  input  bvst_pkg::mem_wr_t                wr,
  output logic                             done,
  output logic signed [bvst_pkg::VAL_W-1:0] value
);
  import bvst_pkg::*;

  logic signed [SMP_W-1:0] row_mem [MAX_ROWS*MAX_LEN];
  logic signed [SMP_W-1:0] mean_mem [MAX_LEN];

  logic                    busy_r;
  logic [CNT_W-1:0]        ic_r;
  logic [MAX_ROWS-1:0]     pat_r;
  logic [CNT_W-1:0]        nrows_r;
  logic [COL_W-1:0]        col_r;
  logic                    tv_r;
  logic                    tmean_r;
  logic                    tadd_r;
  logic                    tlast_r;
  logic signed [SMP_W-1:0] row_q_r;
  logic signed [SMP_W-1:0] mean_q_r;
  logic signed [VAL_W-1:0] acc_r;
  logic                    done_r;
  logic [ROW_W-1:0]        hsel;

  assign hsel = ROW_W'(ic_r - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (wr.row_we) begin
      row_mem[{wr.row, wr.col}] <= wr.data;
    end
    if (wr.mean_we) begin
      mean_mem[wr.col] <= wr.data;
    end
    row_q_r  <= row_mem[{hsel, col_r}];
    mean_q_r <= mean_mem[col_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      ic_r    <= '0;
      tv_r    <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      if (req.start) begin
        busy_r  <= 1'b1;
        ic_r    <= '0;
        pat_r   <= req.pattern;
        nrows_r <= req.nrows;
        col_r   <= req.col;
        tv_r    <= 1'b0;
      end else if (busy_r) begin
        tv_r    <= 1'b1;
        tmean_r <= (ic_r == '0);
        tadd_r  <= pat_r[hsel];
        tlast_r <= (ic_r == nrows_r);
        if (ic_r == nrows_r) begin
          busy_r <= 1'b0;
        end else begin
          ic_r <= ic_r + CNT_W'(1);
        end
      end else begin
        tv_r <= 1'b0;
      end
      done_r <= tv_r && tlast_r;
    end
  end

  always_ff @(posedge clk) begin
    if (tv_r) begin
      if (tmean_r) begin
        acc_r <= VAL_W'(mean_q_r);
      end else if (tadd_r) begin
        acc_r <= acc_r + VAL_W'(row_q_r);
      end
    end
  end

  assign done  = done_r;
  assign value = acc_r;

endmodule

// ===== rtl/bvst_gap.sv =====
// Nearest-level gap and its square, two register stages.
module bvst_gap (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic signed [bvst_pkg::VAL_W-1:0] a,
  input  logic signed [bvst_pkg::SMP_W-1:0] lo,
  input  logic signed [bvst_pkg::SMP_W-1:0] hi,
  output logic                              sq_valid,
  output logic [bvst_pkg::SQ_W-1:0]         sq
);
  import bvst_pkg::*;

  logic signed [SMP_W:0]   mid2;
  logic signed [VAL_W:0]   a2;
  logic signed [VAL_W:0]   gap;
  logic [MAG_W-1:0]        mag_r;
  logic                    v1_r;
  logic                    v2_r;
  logic [SQ_W-1:0]         sq_r;

  always_comb begin
    mid2 = (SMP_W+1)'(lo) + (SMP_W+1)'(hi);
    a2   = {a, 1'b0};
    if (a2 > (VAL_W+1)'(mid2)) begin
      gap = (VAL_W+1)'(hi) - (VAL_W+1)'(a);
    end else begin
      gap = (VAL_W+1)'(lo) - (VAL_W+1)'(a);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= gap[VAL_W] ? MAG_W'(-gap) : MAG_W'(gap);
    sq_r  <= SQ_W'(mag_r) * SQ_W'(mag_r);
  end

  assign sq_valid = v2_r;
  assign sq       = sq_r;

endmodule

// ===== test/bvst_checker.sv =====
// Checker for the binary vertex search block: tracks stores and slots, checks read words.
module bvst_checker
  import bvst_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_wdata,
  output int               errors,
  output int               pending
);

  typedef struct packed {
    logic [15:0]        pat;
    logic [DIST_W-1:0]  dsum;
    logic signed [20:0] val;
  } slot_word_t;

  localparam longint unsigned DIST_SAT = (64'd1 << DIST_W) - 1;

  logic signed [SMP_W-1:0] row_mem [MAX_ROWS][MAX_LEN];
  logic signed [SMP_W-1:0] mean_mem [MAX_LEN];
  logic [15:0]             kept_pat [SLOTS];
  longint unsigned         kept_dist [SLOTS];
  longint unsigned         worst_sum;
  logic [4:0]              rows_reg;
  logic [10:0]             len_reg;
  logic signed [15:0]      low_reg;
  logic signed [15:0]      high_reg;
  slot_word_t              want_q[$];

  initial begin
    errors = 0;
    pending = 0;
    rows_reg = 5'd8;
    len_reg = 11'd1024;
    low_reg = 16'sd0;
    high_reg = 16'sd4096;
    worst_sum = 0;
    for (int s = 0; s < SLOTS; s++) begin
      kept_pat[s] = '0;
      kept_dist[s] = 0;
    end
    for (int c = 0; c < MAX_LEN; c++) begin
      mean_mem[c] = '0;
      for (int r = 0; r < MAX_ROWS; r++) row_mem[r][c] = '0;
    end
  end

  function automatic longint vertex_elem(logic [15:0] p, int col);
    longint a;
    a = mean_mem[col];
    for (int h = 0; h < MAX_ROWS; h++)
      if (p[h]) a += row_mem[h][col];
    return a;
  endfunction

  function automatic longint unsigned vertex_cost(logic [15:0] p, int m);
    longint a, gap, lo, hi;
    longint unsigned sum;
    lo = low_reg;
    hi = high_reg;
    sum = 0;
    for (int j = 0; j < m; j++) begin
      a = vertex_elem(p, j);
      gap = (2 * a > lo + hi) ? hi - a : lo - a;
      if (gap < 0) gap = -gap;
      sum += gap * gap;
      if (sum > DIST_SAT) sum = DIST_SAT;
    end
    return sum;
  endfunction

  task automatic search_topk();
    int k, m;
    longint unsigned d;
    k = (rows_reg < 1) ? 1 : (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
    m = (len_reg < 1) ? 1 : (len_reg > MAX_LEN) ? MAX_LEN : len_reg;
    worst_sum = 0;
    for (int p = 0; p <= k; p++) begin
      d = vertex_cost(p[15:0], m);
      kept_pat[p] = p[15:0];
      kept_dist[p] = d;
      if (d > worst_sum) worst_sum = d;
    end
    for (int p = k + 1; p < (1 << k); p++) begin
      d = vertex_cost(p[15:0], m);
      if (d <= worst_sum) begin
        for (int s = 0; s <= k; s++) begin
          if (kept_dist[s] == worst_sum) begin
            kept_dist[s] = d;
            kept_pat[s] = p[15:0];
            break;
          end
        end
        worst_sum = 0;
        for (int s = 0; s <= k; s++)
          if (kept_dist[s] > worst_sum) worst_sum = kept_dist[s];
      end
    end
  endtask

  always @(negedge clk) begin
    action_t                 act;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [SMP_W-1:0] smp;
    logic [4:0]              slot;
    slot_word_t              w, got;
    longint                  v;
    longint unsigned         dk;
    if (rst_n) begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_ROWS: rows_reg = cfg_wdata[4:0];
          REG_LEN:  len_reg = cfg_wdata[10:0];
          REG_LOW:  low_reg = cfg_wdata;
          REG_HIGH: high_reg = cfg_wdata;
        endcase
      end
      if (in_tvalid && in_tready) begin
        act = action_t'(in_tdata[1:0]);
        row = in_tdata[5:2];
        col = in_tdata[15:6];
        smp = in_tdata[31:16];
        slot = in_tdata[36:32];
        case (act)
          ACT_LOAD_ROW:  row_mem[row][col] = smp;
          ACT_LOAD_MEAN: mean_mem[col] = smp;
          ACT_RUN:       search_topk();
          ACT_READ: begin
            w = '0;
            if (slot < SLOTS) begin
              w.pat = kept_pat[slot];
              dk = kept_dist[slot];
              w.dsum = dk[DIST_W-1:0];
              v = vertex_elem(kept_pat[slot], col);
              if (v > 524287) v = 524287;
              if (v < -524288) v = -524288;
              w.val = v[20:0];
            end
            want_q.push_back(w);
          end
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.pat = out_tdata[15:0];
        got.dsum = out_tdata[71:16];
        got.val = out_tdata[92:72];
        if (want_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none actual %h", $time, got);
        end else begin
          w = want_q.pop_front();
          if (got.pat !== w.pat) begin
            errors++;
            $display("%0t: pattern expected %h actual %h", $time, w.pat, got.pat);
          end
          if (got.dsum !== w.dsum) begin
            errors++;
            $display("%0t: distance expected %h actual %h", $time, w.dsum, got.dsum);
          end
          if (got.val !== w.val) begin
            errors++;
            $display("%0t: value expected %h actual %h", $time, w.val, got.val);
          end
        end
      end
      pending = want_q.size();
    end
  end

endmodule

// ===== test/binary_vertex_search_topk_tb.sv =====
// Testbench top: drives loads, searches, reads and register writes, gives the verdict.
module binary_vertex_search_topk_tb;
  import bvst_pkg::*;

  localparam longint LIMIT = 40_000_000;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [15:0]      cfg_wdata;
  int               errors;
  int               pending;
  bit               tx_steady;
  bit               rx_steady;
  bit               rx_hold;
  longint           cycles = 0;

  binary_vertex_search_topk dut (.*);

  bvst_checker chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [IN_W-1:0] pack_word(action_t a, int row, int col,
                                                int smp, int slot);
    logic [IN_W-1:0] w;
    w = '0;
    w[1:0] = a;
    w[5:2] = row[3:0];
    w[15:6] = col[9:0];
    w[31:16] = smp[15:0];
    w[36:32] = slot[4:0];
    return w;
  endfunction

  function automatic int full_col();
    int c;
    c = $urandom_range(0, 8);
    return (c == 8) ? 1023 : c;
  endfunction

  task automatic put(logic [IN_W-1:0] w);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= w;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
  endtask

  task automatic drain();
    put(pack_word(ACT_READ, 0, 0, 0, 0));
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic read_any(int slot);
    put(pack_word(ACT_READ, $urandom_range(0, 15), full_col(), $urandom, slot));
  endtask

  initial begin
    int g;
    bit held;
    out_tready = 1'b0;
    held = 0;
    @(posedge rst_n);
    forever begin
      g = rx_steady ? 0 : $urandom_range(0, 18);
      if (rx_hold && !held) begin
        g = 600;
        held = 1;
      end
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(negedge clk); while (!out_tvalid);
      @(posedge clk);
    end
  end

  initial begin
    int r, n;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    tx_steady = 0;
    rx_steady = 0;
    rx_hold = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // fill every row and the mean at columns 0..7 and 1023
    for (int c = 0; c < 9; c++) begin
      put(pack_word(ACT_LOAD_MEAN, 0, (c == 8) ? 1023 : c, $urandom, 0));
      for (int h = 0; h < MAX_ROWS; h++)
        put(pack_word(ACT_LOAD_ROW, h, (c == 8) ? 1023 : c, $urandom, 0));
    end
    read_any(0);
    read_any(16);
    read_any(17);
    read_any(31);
    drain();

    write_reg(REG_ROWS, 0);
    write_reg(REG_LEN, 0);
    write_reg(REG_LOW, -32768);
    write_reg(REG_HIGH, 32767);
    put(pack_word(ACT_LOAD_ROW, 0, 0, -32768, 0));
    put(pack_word(ACT_LOAD_MEAN, 0, 0, 32767, 0));
    put(pack_word(ACT_RUN, 0, 0, 0, 0));
    put(pack_word(ACT_READ, 0, 0, 0, 0));
    put(pack_word(ACT_READ, 0, 1023, 0, 1));
    put(pack_word(ACT_READ, 0, 1023, 0, 2));
    put(pack_word(ACT_READ, 0, 0, 0, 16));
    drain();

    write_reg(REG_ROWS, 31);
    write_reg(REG_LEN, 1);
    write_reg(REG_LOW, 32767);
    write_reg(REG_HIGH, -32768);
    put(pack_word(ACT_RUN, 0, 0, 0, 0));
    for (int s = 0; s < SLOTS; s++) read_any(s);
    drain();

    // long vector: mean and row 0 over the first 512 columns
    write_reg(REG_ROWS, 1);
    write_reg(REG_LEN, 512);
    write_reg(REG_LOW, $urandom);
    write_reg(REG_HIGH, $urandom);
    tx_steady = 1;
    for (int c = 0; c < 512; c++) begin
      put(pack_word(ACT_LOAD_MEAN, 0, c, $urandom, 0));
      put(pack_word(ACT_LOAD_ROW, 0, c, $urandom, 0));
    end
    tx_steady = 0;
    put(pack_word(ACT_RUN, 0, 0, 0, 0));
    for (int i = 0; i < 20; i++)
      put(pack_word(ACT_READ, 0, $urandom_range(0, 511), 0, $urandom_range(0, 1)));
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      write_reg(REG_ROWS, ($urandom_range(0, 3) == 0) ? $urandom_range(7, 8)
                                                      : $urandom_range(1, 6));
      write_reg(REG_LEN, $urandom_range(1, 8));
      write_reg(REG_LOW, $urandom);
      write_reg(REG_HIGH, $urandom);
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      if (ph == 2) begin
        rx_hold = 1;
        tx_steady = 1;
      end
      n = 0;
      for (int i = 0; i < 34; i++) begin
        r = $urandom_range(0, 99);
        if (r < 45)
          put(pack_word(ACT_LOAD_ROW, $urandom_range(0, 15),
                        ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : full_col(),
                        $urandom, $urandom));
        else if (r < 58)
          put(pack_word(ACT_LOAD_MEAN, $urandom, full_col(), $urandom, $urandom));
        else if (r < 63 && n < 5) begin
          put(pack_word(ACT_RUN, $urandom, $urandom, $urandom, $urandom));
          n++;
        end else
          read_any(($urandom_range(0, 7) == 0) ? $urandom_range(17, 31)
                                               : $urandom_range(0, 16));
      end
      tx_steady = 0;
      rx_steady = 0;
      drain();
    end

    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bvst_pkg.sv
rtl/bvst_elem.sv
rtl/bvst_gap.sv
rtl/binary_vertex_search_topk.sv
test/bvst_checker.sv
test/binary_vertex_search_topk_tb.sv
